>>> rtl/core/ucrba_pkg.sv
`default_nettype none

package ucrba_pkg;

  // Default sizing of the band and of the user population.
  localparam int NUM_RBS_DEF   = 64;
  localparam int NUM_USERS_DEF = 16;

  // Fixed payload widths of the item channels.
  localparam int FUNC_W   = 2;
  localparam int RB_W     = 6;
  localparam int USER_W   = 4;
  localparam int METRIC_W = 31;
  localparam int DEMAND_W = 16;

  // Configuration register widths and port layout.
  localparam int RBS_CFG_W   = 7;
  localparam int USERS_CFG_W = 5;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [PADDR_W-1:0] ADDR_RBS_IN_USE   = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_USERS_IN_USE = 3'd4;

  localparam logic [RBS_CFG_W-1:0]   RBS_CFG_RESET   = 7'd64;
  localparam logic [USERS_CFG_W-1:0] USERS_CFG_RESET = 5'd16;

  // Function codes carried by an input item.
  localparam logic [FUNC_W-1:0] FUNC_WR_METRIC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_DEMAND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN       = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESERVED  = 2'd3;

  // A metric must be strictly above this floor to be selected.
  localparam logic signed [METRIC_W-1:0] METRIC_FLOOR = 31'sh4000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_PICK,
    ST_EXPAND,
    ST_READ_LEFT,
    ST_DECIDE,
    ST_GRANT_END,
    ST_FINISH,
    ST_OUT_READ,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } alloc_state_t;

endpackage

`default_nettype wire

>>> rtl/core/ucrba_req_if.sv
`default_nettype none

interface ucrba_req_if
  import ucrba_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [RB_W-1:0]            rb_index;
  logic [USER_W-1:0]          user_index;
  logic signed [METRIC_W-1:0] metric_value;
  logic [DEMAND_W-1:0]        demand_blocks;

  modport source (
    output valid, func, rb_index, user_index, metric_value, demand_blocks,
    input  ready
  );
  modport sink (
    input  valid, func, rb_index, user_index, metric_value, demand_blocks,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/ucrba_grant_if.sv
`default_nettype none

interface ucrba_grant_if
  import ucrba_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [USER_W-1:0] granted_user;
  logic [RB_W-1:0]   granted_rb;
  logic              user_last;
  logic              grant_complete;
  logic              nothing_granted;
  logic              run_last;

  modport source (
    output valid, granted_user, granted_rb, user_last, grant_complete,
           nothing_granted, run_last,
    input  ready
  );
  modport sink (
    input  valid, granted_user, granted_rb, user_last, grant_complete,
           nothing_granted, run_last,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/uplink_contiguous_rb_allocator_unit.sv
// Load items (metric or demand writes) are accepted back to back, one per cycle, while idle;
// a run item holds the input until its last result is out. Each granting round scans the
// block-user pairs and expands the grant, and results leave subject to output stalls; the
// single read port of the metric store sets the scan at one metric per cycle.
// Reset (rst, synchronous, active high) restores the register defaults and clears the
// control state; the metric and demand stores keep no reset and must be written before use.
`default_nettype none

module uplink_contiguous_rb_allocator_unit
  import ucrba_pkg::*;
#(
  parameter int NUM_RBS   = NUM_RBS_DEF,
  parameter int NUM_USERS = NUM_USERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  ucrba_req_if.sink               req,
  ucrba_grant_if.source           grant
);

  // Index widths: block, user, block count (holds NUM_RBS itself), user count,
  // and the metric store address.
  localparam int RW    = (NUM_RBS > 1) ? $clog2(NUM_RBS) : 1;
  localparam int UW    = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int CW    = $clog2(NUM_RBS + 1);
  localparam int UCW   = $clog2(NUM_USERS + 1);
  localparam int DEPTH = NUM_RBS * NUM_USERS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  alloc_state_t state, state_next;

  // Configuration registers.
  logic [RBS_CFG_W-1:0]   rbs_in_use;
  logic [USERS_CFG_W-1:0] users_in_use;
  logic                   cfg_write;

  // Run bookkeeping.
  logic [CW-1:0]  nb;
  logic [UCW-1:0] nu;
  logic [CW-1:0]  avail;
  logic [UCW-1:0] unserved;
  logic [CW-1:0]  count;
  logic [CW-1:0]  ocnt;
  logic [NUM_RBS-1:0]   taken;
  logic [NUM_USERS-1:0] served;
  logic [NUM_RBS-1:0]   ulast;
  logic                 done_flag [NUM_USERS];

  // Demand per user, saturated to the block count when written.
  logic [CW-1:0] demand_mem [NUM_USERS];

  // Scan counters, the pipeline registers behind the metric read, and the best hit.
  logic [RW-1:0]              si;
  logic [UW-1:0]              sj;
  logic                       pq;
  logic [RW-1:0]              pi;
  logic [UW-1:0]              pj;
  logic [CW-1:0]              pdem;
  logic signed [METRIC_W-1:0] best;
  logic                       found;
  logic [RW-1:0]              sel_i;
  logic [UW-1:0]              sel_j;
  logic [CW-1:0]              sel_dem;

  // Expansion state.
  logic [RW-1:0]              left;
  logic                       left_ok;
  logic [CW-1:0]              right;
  logic [CW-1:0]              k;
  logic                       made;
  logic                       lf;
  logic                       rf;
  logic signed [METRIC_W-1:0] mr;

  // Grant results held until the run has finished, since grant_complete and
  // run_last are only known at the end.
  logic [UW+RW-1:0] res_mem [NUM_RBS];
  logic [UW+RW-1:0] res_rdata;

  // Output register.
  logic              out_valid;
  logic [USER_W-1:0] out_user;
  logic [RB_W-1:0]   out_rb;
  logic              out_ulast;
  logic              out_complete;
  logic              out_none;
  logic              out_run_last;

  // Metric store ports.
  logic                wr_en;
  logic [AW-1:0]       waddr;
  logic                rd_en;
  logic [AW-1:0]       raddr;
  logic [METRIC_W-1:0] rdata;

  logic in_accept;
  logic scan_q;
  logic scan_last;
  logic lfree;
  logic rfree;
  logic may_grow;
  logic take_right;
  logic [RW-1:0] grow_blk;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads are
  // combinational on the register values.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rbs_in_use   <= RBS_CFG_RESET;
      users_in_use <= USERS_CFG_RESET;
    end else if (cfg_write) begin
      if (paddr == ADDR_RBS_IN_USE) begin
        rbs_in_use <= pwdata[RBS_CFG_W-1:0];
      end else if (paddr == ADDR_USERS_IN_USE) begin
        users_in_use <= pwdata[USERS_CFG_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_RBS_IN_USE) begin
      prdata = PDATA_W'(rbs_in_use);
    end else if (paddr == ADDR_USERS_IN_USE) begin
      prdata = PDATA_W'(users_in_use);
    end
  end

  // ---------------------------------------------------------------------------
  // Metric store. Load items write it directly; the sequencer reads it.
  // ---------------------------------------------------------------------------
  assign in_accept = req.valid && req.ready;
  assign wr_en = in_accept && (req.func == FUNC_WR_METRIC) &&
                 (int'(req.rb_index) < NUM_RBS) && (int'(req.user_index) < NUM_USERS);
  assign waddr = AW'(int'(req.rb_index) * NUM_USERS + int'(req.user_index));

  ucrba_metric_ram #(
    .DEPTH (DEPTH)
  ) u_metric_ram (
    .clk   (clk),
    .wr_en (wr_en),
    .waddr (waddr),
    .wdata (req.metric_value),
    .rd_en (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A block-user pair takes part in the scan only if the block is free and the
  // user is unserved with some demand.
  assign scan_q    = !taken[si] && !served[sj] && (demand_mem[sj] != '0);
  assign scan_last = (CW'(si) == nb - CW'(1)) && (UCW'(sj) == nu - UCW'(1));

  // Neighbour availability during expansion; the left edge is tracked by
  // left_ok, the right edge by comparing with the band size.
  assign lfree    = left_ok && !taken[left];
  assign rfree    = (right < nb) && !taken[right[RW-1:0]];
  assign may_grow = (k < sel_dem) && (avail != '0);

  // Equal metrics on both sides favour the right-hand block.
  assign take_right = rf && (!lf || (mr >= $signed(rdata)));
  assign grow_blk   = take_right ? right[RW-1:0] : left;

  // ---------------------------------------------------------------------------
  // Sequencer: next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && (req.func == FUNC_RUN)) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if ((avail != '0) && (unserved != '0)) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: state_next = ST_PICK;
      ST_PICK: begin
        state_next = found ? ST_EXPAND : ST_FINISH;
      end
      ST_EXPAND: begin
        if (may_grow && (lfree || rfree)) begin
          state_next = ST_READ_LEFT;
        end else begin
          state_next = ST_GRANT_END;
        end
      end
      ST_READ_LEFT: state_next = ST_DECIDE;
      ST_DECIDE:    state_next = ST_EXPAND;
      ST_GRANT_END: state_next = ST_ROUND;
      ST_FINISH: begin
        state_next = (count == '0) ? ST_OUT_WAIT : ST_OUT_READ;
      end
      ST_OUT_READ: state_next = ST_OUT_LOAD;
      ST_OUT_LOAD: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (grant.ready) begin
          state_next = out_run_last ? ST_IDLE : ST_OUT_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs. Only the metric read port and the input handshake are
  // decoded here; everything else is registered below.
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_en     = 1'b0;
    raddr     = AW'(int'(si) * NUM_USERS + int'(sj));
    req.ready = 1'b0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: rd_en = 1'b1;
      ST_EXPAND: begin
        rd_en = may_grow && rfree;
        raddr = AW'(int'(right[RW-1:0]) * NUM_USERS + int'(sel_j));
      end
      ST_READ_LEFT: begin
        rd_en = lf;
        raddr = AW'(int'(left) * NUM_USERS + int'(sel_j));
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      taken     <= '0;
      served    <= '0;
      ulast     <= '0;
      out_valid <= 1'b0;
      pq        <= 1'b0;
    end else begin
      state <= state_next;
      pq    <= (state == ST_SCAN) && scan_q;
      case (state)
        ST_IDLE: begin
          if (in_accept && (req.func == FUNC_RUN)) begin
            taken  <= '0;
            served <= '0;
            ulast  <= '0;
          end
        end
        ST_PICK: begin
          if (found) begin
            taken[sel_i]  <= 1'b1;
            served[sel_j] <= 1'b1;
          end
        end
        ST_DECIDE: taken[grow_blk] <= 1'b1;
        ST_GRANT_END: ulast[RW'(count - CW'(1))] <= 1'b1;
        ST_FINISH: begin
          if (count == '0) begin
            out_valid <= 1'b1;
          end
        end
        ST_OUT_LOAD: out_valid <= 1'b1;
        ST_OUT_WAIT: begin
          if (grant.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept && (req.func == FUNC_WR_DEMAND) && (int'(req.user_index) < NUM_USERS)) begin
      demand_mem[UW'(req.user_index)] <= (req.demand_blocks > DEMAND_W'(NUM_RBS)) ?
                                         CW'(NUM_RBS) : CW'(req.demand_blocks);
    end

    pi   <= si;
    pj   <= sj;
    pdem <= demand_mem[sj];

    // Metric comparison on the registered read data; the first strict maximum wins.
    if (pq && ($signed(rdata) > best)) begin
      best    <= $signed(rdata);
      found   <= 1'b1;
      sel_i   <= pi;
      sel_j   <= pj;
      sel_dem <= pdem;
    end

    case (state)
      ST_IDLE: begin
        if (in_accept && (req.func == FUNC_RUN)) begin
          nb       <= (int'(rbs_in_use) > NUM_RBS) ? CW'(NUM_RBS) : CW'(rbs_in_use);
          avail    <= (int'(rbs_in_use) > NUM_RBS) ? CW'(NUM_RBS) : CW'(rbs_in_use);
          nu       <= (int'(users_in_use) > NUM_USERS) ? UCW'(NUM_USERS) : UCW'(users_in_use);
          unserved <= (int'(users_in_use) > NUM_USERS) ? UCW'(NUM_USERS) : UCW'(users_in_use);
          count    <= '0;
        end
      end
      ST_ROUND: begin
        si    <= '0;
        sj    <= '0;
        best  <= METRIC_FLOOR;
        found <= 1'b0;
      end
      ST_SCAN: begin
        if (UCW'(sj) == nu - UCW'(1)) begin
          sj <= '0;
          si <= si + RW'(1);
        end else begin
          sj <= sj + UW'(1);
        end
      end
      ST_PICK: begin
        if (found) begin
          res_mem[count[RW-1:0]] <= {sel_j, sel_i};
          count    <= count + CW'(1);
          avail    <= avail - CW'(1);
          unserved <= unserved - UCW'(1);
          left     <= sel_i - RW'(1);
          left_ok  <= (sel_i != '0);
          right    <= CW'(sel_i) + CW'(1);
          k        <= CW'(1);
          made     <= 1'b1;
        end
      end
      ST_EXPAND: begin
        lf <= lfree;
        rf <= rfree;
        if (may_grow && !lfree && !rfree) begin
          made <= 1'b0;
        end
      end
      ST_READ_LEFT: mr <= $signed(rdata);
      ST_DECIDE: begin
        res_mem[count[RW-1:0]] <= {sel_j, grow_blk};
        count <= count + CW'(1);
        avail <= avail - CW'(1);
        k     <= k + CW'(1);
        if (take_right) begin
          right <= right + CW'(1);
        end else begin
          left_ok <= (left != '0);
          left    <= left - RW'(1);
        end
      end
      ST_GRANT_END: done_flag[sel_j] <= made;
      ST_FINISH: begin
        ocnt <= '0;
        if (count == '0) begin
          out_user     <= '0;
          out_rb       <= '0;
          out_ulast    <= 1'b0;
          out_complete <= 1'b0;
          out_none     <= 1'b1;
          out_run_last <= 1'b1;
        end
      end
      ST_OUT_READ: res_rdata <= res_mem[ocnt[RW-1:0]];
      ST_OUT_LOAD: begin
        out_user     <= USER_W'(res_rdata[UW+RW-1:RW]);
        out_rb       <= RB_W'(res_rdata[RW-1:0]);
        out_ulast    <= ulast[ocnt[RW-1:0]];
        out_complete <= done_flag[res_rdata[UW+RW-1:RW]];
        out_none     <= 1'b0;
        out_run_last <= (ocnt == count - CW'(1));
      end
      ST_OUT_WAIT: begin
        if (grant.ready) begin
          ocnt <= ocnt + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign grant.valid           = out_valid;
  assign grant.granted_user    = out_user;
  assign grant.granted_rb      = out_rb;
  assign grant.user_last       = out_ulast;
  assign grant.grant_complete  = out_complete;
  assign grant.nothing_granted = out_none;
  assign grant.run_last        = out_run_last;

endmodule

`default_nettype wire

>>> rtl/core/ucrba_metric_ram.sv
`default_nettype none

// Single-port-write, single-port-read metric store with registered read data.
module ucrba_metric_ram
  import ucrba_pkg::*;
#(
  parameter  int DEPTH = NUM_RBS_DEF * NUM_USERS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [METRIC_W-1:0] wdata,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       raddr,
  output logic      [METRIC_W-1:0] rdata
);

  logic [METRIC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ucrba_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The slowest
  // correct stretch is a run over the full 64 x 16 band: a scan of the block-user pairs
  // in each round, plus expansion and the receiver's long hold-off.
  localparam int HANG_LIMIT = 100000;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES = 12;

  // One load or run item as the controller would send it.
  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [RB_W-1:0]     rb;
    logic [USER_W-1:0]   usr;
    logic [METRIC_W-1:0] metric;
    logic [DEMAND_W-1:0] demand;
  } load_item_t;

  // One granted block as it leaves the allocator.
  typedef struct packed {
    logic [USER_W-1:0] usr;
    logic [RB_W-1:0]   rb;
    logic              ulast;
    logic              cmp;
    logic              none;
    logic              rlast;
  } grant_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  wire  [PDATA_W-1:0] prdata;
  wire                pready;

  ucrba_req_if   req_ch();
  ucrba_grant_if grant_ch();

  uplink_contiguous_rb_allocator_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch.sink),
    .grant   (grant_ch.source)
  );

  // Items waiting to be offered, and grants the allocator still owes us.
  load_item_t pending_loads[$];
  grant_t     expected_grants[$];

  // Our own copy of the allocator's stores and registers, updated as items are accepted.
  int pm_metric [NUM_RBS_DEF*NUM_USERS_DEF];
  int pm_demand [NUM_USERS_DEF];
  int pm_rbs;
  int pm_users;

  // Register values the stimulus is currently built for, which store entries have
  // been loaded at least once, and the demand each user will hold once the queue has
  // drained. A run must never scan an entry that was never written.
  int  cur_rbs;
  int  cur_users;
  bit  metric_loaded [NUM_RBS_DEF*NUM_USERS_DEF];
  bit  demand_loaded [NUM_USERS_DEF];
  int  pend_demand [NUM_USERS_DEF];

  int  errors;
  int  quiet_cycles;
  int  hold_left;
  bit  held_once;
  bit  calm;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Work out every grant that a run item causes, in the order the allocator emits
  // them: the strictly best free (block, user) pair wins a round, first hit kept, and
  // the grant then grows one block at a time, the right side winning a tie.
  task automatic compute_grants();
    int nb, nu, avail, unserved, best, sel_rb, sel_usr, lft, rgt, first, k;
    bit made, lfree, rfree;
    bit taken [NUM_RBS_DEF];
    bit served [NUM_USERS_DEF];
    grant_t g;
    grant_t run_q[$];
    nb = (pm_rbs > NUM_RBS_DEF) ? NUM_RBS_DEF : pm_rbs;
    nu = (pm_users > NUM_USERS_DEF) ? NUM_USERS_DEF : pm_users;
    avail = nb;
    unserved = nu;
    foreach (taken[i]) taken[i] = 1'b0;
    foreach (served[i]) served[i] = 1'b0;
    while (avail > 0 && unserved > 0) begin
      best = -(1 << 30);
      sel_rb = -1;
      sel_usr = -1;
      for (int i = 0; i < nb; i++) begin
        for (int j = 0; j < nu; j++) begin
          if (!taken[i] && !served[j] && pm_demand[j] > 0 &&
              pm_metric[i*NUM_USERS_DEF+j] > best) begin
            best = pm_metric[i*NUM_USERS_DEF+j];
            sel_rb = i;
            sel_usr = j;
          end
        end
      end
      if (sel_usr < 0) break;
      first = run_q.size();
      lft = sel_rb - 1;
      rgt = sel_rb + 1;
      made = 1'b1;
      taken[sel_rb] = 1'b1;
      served[sel_usr] = 1'b1;
      avail--;
      unserved--;
      g = '0;
      g.usr = USER_W'(sel_usr);
      g.rb = RB_W'(sel_rb);
      run_q.insert(run_q.size(), g);
      for (k = 1; k < pm_demand[sel_usr] && avail > 0 && made; k++) begin
        lfree = (lft >= 0) && !taken[lft];
        rfree = (rgt < nb) && !taken[rgt];
        made = 1'b0;
        if (!lfree && !rfree) break;
        if (rfree && (!lfree || pm_metric[rgt*NUM_USERS_DEF+sel_usr] >=
                                pm_metric[lft*NUM_USERS_DEF+sel_usr])) begin
          taken[rgt] = 1'b1;
          g.rb = RB_W'(rgt);
          rgt++;
        end else begin
          taken[lft] = 1'b1;
          g.rb = RB_W'(lft);
          lft--;
        end
        run_q.insert(run_q.size(), g);
        made = 1'b1;
        avail--;
      end
      // Completion is only known once expansion stops, so it is set on the whole grant.
      for (int i = first; i < run_q.size(); i++) run_q[i].cmp = made;
      run_q[run_q.size()-1].ulast = 1'b1;
    end
    if (run_q.size() == 0) begin
      g = '0;
      g.none = 1'b1;
      run_q.insert(run_q.size(), g);
    end
    run_q[run_q.size()-1].rlast = 1'b1;
    foreach (run_q[i]) expected_grants.insert(expected_grants.size(), run_q[i]);
  endtask

  // Sender: a new item is offered when the previous one has gone, unless we idle.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_loads.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
        load_item_t it;
        it = pending_loads.pop_front();
        req_ch.valid         <= 1'b1;
        req_ch.func          <= it.func;
        req_ch.rb_index      <= it.rb;
        req_ch.user_index    <= it.usr;
        req_ch.metric_value  <= it.metric;
        req_ch.demand_blocks <= it.demand;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off taken while items are still being
  // offered, so the allocator's output backs up and it has to stall its input.
  always @(posedge clk) begin
    if (rst) begin
      grant_ch.ready <= 1'b0;
      hold_left <= 0;
      held_once <= 1'b0;
    end else if (hold_left > 0) begin
      grant_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_once && grant_ch.valid && pending_loads.size() != 0) begin
      grant_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      held_once <= 1'b1;
    end else begin
      grant_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  // Monitor: accepted input items update our copy of the stores; accepted grants are
  // compared with the oldest one owed.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        case (req_ch.func)
          FUNC_WR_METRIC: pm_metric[req_ch.rb_index*NUM_USERS_DEF+req_ch.user_index] =
                            int'($signed(req_ch.metric_value));
          FUNC_WR_DEMAND: pm_demand[req_ch.user_index] =
                            (req_ch.demand_blocks > NUM_RBS_DEF) ? NUM_RBS_DEF
                                                                 : req_ch.demand_blocks;
          FUNC_RUN:       compute_grants();
          default: ;
        endcase
      end
      if (grant_ch.valid && grant_ch.ready) begin
        if (expected_grants.size() == 0) begin
          report("unexpected grant, user", grant_ch.granted_user, -1);
        end else begin
          grant_t w;
          w = expected_grants.pop_front();
          if (grant_ch.granted_user !== w.usr) report("granted_user", grant_ch.granted_user, w.usr);
          if (grant_ch.granted_rb !== w.rb) report("granted_rb", grant_ch.granted_rb, w.rb);
          if (grant_ch.user_last !== w.ulast) report("user_last", grant_ch.user_last, w.ulast);
          if (grant_ch.grant_complete !== w.cmp)
            report("grant_complete", grant_ch.grant_complete, w.cmp);
          if (grant_ch.nothing_granted !== w.none)
            report("nothing_granted", grant_ch.nothing_granted, w.none);
          if (grant_ch.run_last !== w.rlast) report("run_last", grant_ch.run_last, w.rlast);
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (grant_ch.valid && grant_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  task automatic push_item(logic [FUNC_W-1:0] f, int rb, int usr, logic [METRIC_W-1:0] m,
                           logic [DEMAND_W-1:0] d);
    load_item_t it;
    it.func = f;
    it.rb = RB_W'(rb);
    it.usr = USER_W'(usr);
    it.metric = m;
    it.demand = d;
    if (f == FUNC_WR_METRIC) metric_loaded[rb*NUM_USERS_DEF+usr] = 1'b1;
    if (f == FUNC_WR_DEMAND) begin
      demand_loaded[usr] = 1'b1;
      pend_demand[usr] = (d > NUM_RBS_DEF) ? NUM_RBS_DEF : int'(d);
    end
    pending_loads.insert(pending_loads.size(), it);
  endtask

  function automatic logic [METRIC_W-1:0] pick_metric();
    case ($urandom_range(0, 7))
      0: return 31'h3FFF_FFFF;         // largest metric
      1: return 31'h4000_0001;         // most negative legal metric
      2: return METRIC_FLOOR;          // sits on the floor, never selected
      3, 4: return METRIC_W'($urandom_range(0, 3));
      5: return -METRIC_W'($urandom_range(0, 3));
      default: return METRIC_W'($urandom());
    endcase
  endfunction

  // Before a run, load whatever the scan would read that has never been written. Metrics
  // of users without demand are never compared, so only users with demand need them.
  task automatic queue_run();
    int nb, nu;
    nb = (cur_rbs > NUM_RBS_DEF) ? NUM_RBS_DEF : cur_rbs;
    nu = (cur_users > NUM_USERS_DEF) ? NUM_USERS_DEF : cur_users;
    for (int j = 0; j < nu; j++)
      if (!demand_loaded[j]) push_item(FUNC_WR_DEMAND, 0, j, '0, DEMAND_W'($urandom_range(0, 4)));
    for (int i = 0; i < nb; i++)
      for (int j = 0; j < nu; j++)
        if (pend_demand[j] != 0 && !metric_loaded[i*NUM_USERS_DEF+j])
          push_item(FUNC_WR_METRIC, i, j, pick_metric(), '0);
    push_item(FUNC_RUN, $urandom_range(0, 63), $urandom_range(0, 15), pick_metric(),
              DEMAND_W'($urandom()));
  endtask

  // Full band with a single user asking for blocks, so that only this user's metrics
  // have to be loaded.
  task automatic queue_large();
    int want;
    for (int j = 0; j < NUM_USERS_DEF; j++) begin
      want = (j == 0) ? $urandom_range(1, 70) : 0;
      if (!demand_loaded[j] || pend_demand[j] != ((want > NUM_RBS_DEF) ? NUM_RBS_DEF : want))
        push_item(FUNC_WR_DEMAND, 0, j, '0, DEMAND_W'(want));
    end
    queue_run();
  endtask

  task automatic queue_random(int count);
    int nb, r;
    nb = (cur_rbs > NUM_RBS_DEF) ? NUM_RBS_DEF : cur_rbs;
    if (nb == 0) nb = 1;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        push_item(FUNC_WR_METRIC,
                  ($urandom_range(0, 4) != 0) ? $urandom_range(0, nb - 1) : $urandom_range(0, 63),
                  $urandom_range(0, 15), pick_metric(), DEMAND_W'($urandom()));
      end else if (r < 68) begin
        push_item(FUNC_WR_DEMAND, $urandom_range(0, 63), $urandom_range(0, 15), pick_metric(),
                  (r < 60) ? DEMAND_W'($urandom_range(0, 4)) :
                  (r < 65) ? DEMAND_W'($urandom_range(0, nb)) : DEMAND_W'($urandom()));
      end else if (r < 73) begin
        // Unused function code: the allocator must drop it.
        push_item(FUNC_RESERVED, $urandom_range(0, 63), $urandom_range(0, 15), pick_metric(),
                  DEMAND_W'($urandom()));
      end else if (r < 85) begin
        queue_run();
      end else begin
        push_item(FUNC_WR_METRIC, $urandom_range(0, nb - 1), $urandom_range(0, 15),
                  METRIC_W'($urandom()), '0);
      end
    end
    queue_run();
  endtask

  // Small band of three blocks and three users covering the field extremes, a metric
  // on the floor, a saturated demand, a zero demand, an empty run and an expansion tie.
  task automatic queue_directed();
    push_item(FUNC_WR_METRIC, 0, 0, 31'h4000_0001, '0);
    push_item(FUNC_WR_METRIC, 1, 0, 31'h3FFF_FFFF, '0);
    push_item(FUNC_WR_METRIC, 2, 0, 31'd5, '0);
    for (int i = 0; i < 3; i++) push_item(FUNC_WR_METRIC, i, 1, METRIC_FLOOR, '0);
    for (int i = 0; i < 3; i++) push_item(FUNC_WR_METRIC, i, 2, 31'd7, '0);
    push_item(FUNC_WR_DEMAND, 0, 0, '0, 16'hFFFF);
    push_item(FUNC_WR_DEMAND, 0, 1, '0, 16'd2);
    push_item(FUNC_WR_DEMAND, 0, 2, '0, 16'd1);
    push_item(FUNC_RESERVED, 63, 15, 31'h7FFF_FFFF, 16'hFFFF);
    push_item(FUNC_RUN, 0, 0, '0, '0);
    push_item(FUNC_WR_DEMAND, 0, 0, '0, 16'd0);
    push_item(FUNC_RUN, 0, 0, '0, '0);
    // Only the user sitting on the floor is left with demand: nothing is granted.
    push_item(FUNC_WR_DEMAND, 0, 2, '0, 16'd0);
    push_item(FUNC_RUN, 0, 0, '0, '0);
    // Equal metrics either side of the winning block: the right side must be taken.
    push_item(FUNC_WR_DEMAND, 0, 2, '0, 16'd3);
    push_item(FUNC_WR_METRIC, 1, 2, 31'd9, '0);
    push_item(FUNC_RUN, 0, 0, '0, '0);
  endtask

  task automatic reg_write(logic [PADDR_W-1:0] addr, int value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Registers may only change with the allocator idle, so everything queued must have
  // gone in and every grant owed must have come out, then the last load is given time to settle.
  task automatic wait_idle();
    while (pending_loads.size() != 0 || req_ch.valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int phase_rbs   [NUM_PHASES] = '{3, 0, 5, 64, 127, 1, 8, 1, 10, 16, 7, 12};
    int phase_users [NUM_PHASES] = '{3, 5, 0, 16, 31, 1, 1, 4, 3, 2, 4, 3};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_ch.valid = 1'b0;
    req_ch.func = '0;
    req_ch.rb_index = '0;
    req_ch.user_index = '0;
    req_ch.metric_value = '0;
    req_ch.demand_blocks = '0;
    grant_ch.ready = 1'b0;
    errors = 0;
    calm = 1'b0;
    pm_rbs = RBS_CFG_RESET;
    pm_users = USERS_CFG_RESET;
    foreach (pm_metric[i]) pm_metric[i] = 0;
    foreach (pm_demand[i]) pm_demand[i] = 0;
    foreach (metric_loaded[i]) metric_loaded[i] = 1'b0;
    foreach (demand_loaded[i]) demand_loaded[i] = 1'b0;
    foreach (pend_demand[i]) pend_demand[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      reg_write(ADDR_RBS_IN_USE, phase_rbs[p]);
      reg_write(ADDR_USERS_IN_USE, phase_users[p]);
      pm_rbs = phase_rbs[p];
      pm_users = phase_users[p];
      cur_rbs = phase_rbs[p];
      cur_users = phase_users[p];
      // A band register set to exactly the full size runs without random idling on either side.
      calm = (phase_rbs[p] == NUM_RBS_DEF);
      if (p == 0) queue_directed();
      if (phase_rbs[p] * phase_users[p] > 256) queue_large();
      else queue_random(8);
    end
    wait_idle();
    repeat (50) @(posedge clk);

    if (expected_grants.size() != 0) report("grants never delivered", 0,
                                            expected_grants.size());
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
